// ===== src/wmfp_pkg.sv =====
// Package: phase codes, field kinds, status codes and tables for the frame parser.
`default_nettype none
package wmfp_pkg;

  typedef enum logic [4:0] {
    PH_TYPE = 5'd0, PH_FLAGS = 5'd1, PH_DUR = 5'd2, PH_RA = 5'd3, PH_TA = 5'd4,
    PH_A3 = 5'd5, PH_SEQ = 5'd6, PH_A4 = 5'd7, PH_QOS = 5'd8, PH_SNAP = 5'd9,
    PH_ETYPE = 5'd10, PH_PAYLOAD = 5'd11, PH_AUTHALG = 5'd12, PH_AUTHSEQ = 5'd13,
    PH_STATUS = 5'd14, PH_REASON = 5'd15, PH_CAP = 5'd16, PH_LISTEN = 5'd17,
    PH_CURAP = 5'd18, PH_AID = 5'd19, PH_TSTAMP = 5'd20, PH_BINT = 5'd21,
    PH_SSID_ID = 5'd22, PH_SSID_LEN = 5'd23, PH_SSID_BYTES = 5'd24,
    PH_RATE_ID = 5'd25, PH_RATE_LEN = 5'd26, PH_RATE_BYTES = 5'd27,
    PH_TAIL = 5'd28, PH_SKIP = 5'd29
  } phase_t;

  localparam logic [4:0] KIND_PAYLOAD = 5'd10;
  localparam logic [4:0] KIND_SSID    = 5'd20;
  localparam logic [4:0] KIND_RATE    = 5'd21;
  localparam logic [4:0] KIND_END     = 5'd22;
  localparam logic [4:0] NO_REC       = 5'd31;

  localparam logic [2:0] ST_OK = 3'd0, ST_CRC = 3'd1, ST_UNSUP = 3'd2, ST_ACT_IGN = 3'd3,
                         ST_TRUNC = 3'd4, ST_EXTRA = 3'd5;

  localparam logic [7:0] T_ACK = 8'hD4, T_RTS = 8'hB4, T_CTS = 8'hC4, T_DATA = 8'h08,
    T_QDATA = 8'h88, T_AUTH = 8'hB0, T_DEAUTH = 8'hC0, T_DISAS = 8'hA0, T_PREQ = 8'h40,
    T_AREQ = 8'h00, T_RAREQ = 8'h20, T_ARSP = 8'h10, T_RARSP = 8'h30, T_BEACON = 8'h80,
    T_PRSP = 8'h50, T_ACTION = 8'hD0;
  localparam logic [7:0] RATE_MASK = 8'h7F;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // one result record
  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] value;
    logic [3:0]  frag;
    logic [7:0]  idx;
    logic        done;
    logic [2:0]  status;
  } rec_t;

  function automatic logic [3:0] phase_len(input phase_t ph);
    case (ph)
      PH_DUR, PH_SEQ, PH_QOS, PH_ETYPE, PH_AUTHALG, PH_AUTHSEQ, PH_STATUS, PH_REASON,
      PH_CAP, PH_LISTEN, PH_AID, PH_BINT: phase_len = 4'd2;
      PH_RA, PH_TA, PH_A3, PH_A4, PH_SNAP, PH_CURAP: phase_len = 4'd6;
      PH_TSTAMP: phase_len = 4'd8;
      default: phase_len = 4'd1;
    endcase
  endfunction

  function automatic logic [4:0] phase_kind(input phase_t ph);
    case (ph)
      PH_DUR: phase_kind = 5'd2;     PH_RA: phase_kind = 5'd3;
      PH_TA: phase_kind = 5'd4;      PH_A3: phase_kind = 5'd5;
      PH_SEQ: phase_kind = 5'd6;     PH_A4: phase_kind = 5'd7;
      PH_QOS: phase_kind = 5'd8;     PH_ETYPE: phase_kind = 5'd9;
      PH_AUTHSEQ: phase_kind = 5'd11; PH_STATUS: phase_kind = 5'd12;
      PH_REASON: phase_kind = 5'd13; PH_CAP: phase_kind = 5'd14;
      PH_LISTEN: phase_kind = 5'd15; PH_CURAP: phase_kind = 5'd16;
      PH_AID: phase_kind = 5'd17;    PH_TSTAMP: phase_kind = 5'd18;
      PH_BINT: phase_kind = 5'd19;
      default: phase_kind = NO_REC;
    endcase
  endfunction

  function automatic logic is_known(input logic [7:0] t);
    case (t)
      T_ACK, T_RTS, T_CTS, T_DATA, T_QDATA, T_AUTH, T_DEAUTH, T_DISAS, T_PREQ,
      T_AREQ, T_RAREQ, T_ARSP, T_RARSP, T_BEACON, T_PRSP: is_known = 1'b1;
      default: is_known = 1'b0;
    endcase
  endfunction

  function automatic phase_t body_start(input logic [7:0] t);
    case (t)
      T_AUTH: body_start = PH_AUTHALG;
      T_DEAUTH, T_DISAS: body_start = PH_REASON;
      T_PREQ: body_start = PH_SSID_ID;
      T_AREQ, T_RAREQ, T_ARSP, T_RARSP: body_start = PH_CAP;
      T_BEACON, T_PRSP: body_start = PH_TSTAMP;
      default: body_start = PH_TAIL;
    endcase
  endfunction

  function automatic phase_t next_phase(input phase_t ph, input logic [7:0] t,
                                        input logic [1:0] ds);
    logic dat;
    dat = (t == T_DATA) || (t == T_QDATA);
    case (ph)
      PH_DUR: next_phase = PH_RA;
      PH_RA: next_phase = (t == T_ACK || t == T_CTS) ? PH_TAIL : PH_TA;
      PH_TA: next_phase = (t == T_RTS) ? PH_TAIL : PH_A3;
      PH_A3: next_phase = PH_SEQ;
      PH_SEQ: begin
        if (!dat) next_phase = body_start(t);
        else if (ds == 2'b11) next_phase = PH_A4;
        else next_phase = (t == T_QDATA) ? PH_QOS : PH_SNAP;
      end
      PH_A4: next_phase = (t == T_QDATA) ? PH_QOS : PH_SNAP;
      PH_QOS: next_phase = PH_SNAP;
      PH_SNAP: next_phase = PH_ETYPE;
      PH_ETYPE: next_phase = PH_PAYLOAD;
      PH_AUTHALG: next_phase = PH_AUTHSEQ;
      PH_AUTHSEQ: next_phase = PH_STATUS;
      PH_STATUS: next_phase = (t == T_AUTH) ? PH_TAIL : PH_AID;
      PH_REASON: next_phase = PH_TAIL;
      PH_CAP: begin
        if (t == T_AREQ || t == T_RAREQ) next_phase = PH_LISTEN;
        else if (t == T_ARSP || t == T_RARSP) next_phase = PH_STATUS;
        else next_phase = PH_SSID_ID;
      end
      PH_LISTEN: next_phase = (t == T_RAREQ) ? PH_CURAP : PH_SSID_ID;
      PH_CURAP: next_phase = PH_SSID_ID;
      PH_AID: next_phase = PH_RATE_ID;
      PH_TSTAMP: next_phase = PH_BINT;
      PH_BINT: next_phase = PH_CAP;
      default: next_phase = PH_TAIL;
    endcase
  endfunction

  // one byte of reflected CRC-32
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] v);
    logic [31:0] c;
    c = crc ^ {24'd0, v};
    for (int i = 0; i < 8; i++) c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/wifi_mac_frame_parser.sv =====
// Top level: byte-serial wireless LAN MAC frame parser.
//   channel | dir | tdata                        | tuser / tlast
//   in_     | in  | [7:0] data_byte              | tlast = last_byte
//   out_    | out | [63:0] field_value, [71:64]  | tuser: kind, frag, done, status
//                     element_index              |
// One byte per cycle unless the output stalls: the byte register feeds phase decode
// and one CRC byte step, then one record register. Input is taken whenever the byte
// register is free or drains this cycle; the record register holds while out_tready is low.
// Synchronous active-low reset returns the parser to the frame type byte.
`default_nettype none
module wifi_mac_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [63:0] field_value, [71:64] element_index
  output logic [12:0]      out_tuser   // [4:0] kind, [8:5] frag, [9] done, [12:10] status
);
  logic            bv_r;
  logic [7:0]      b_r;
  logic            l_r;
  logic            ov_r;
  wmfp_pkg::rec_t  o_r;
  logic            step, rel_ok, full_nxt, rv;
  logic [7:0]      rel_byte;
  logic [31:0]     crc_nxt, fcs_nxt;
  wmfp_pkg::rec_t  rec;

  // a byte steps when its record (if any) has room
  assign step      = bv_r && (!ov_r || out_tready);
  assign in_tready = !bv_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) bv_r <= 1'b0;
    else if (in_tready) bv_r <= in_tvalid;
    if (in_tready && in_tvalid) begin
      b_r <= in_tdata; l_r <= in_tlast;
    end
  end

  wmfp_trail u_trail (.clk, .rst_n, .step, .clear(l_r), .data_byte(b_r),
                      .rel_ok, .rel_byte, .crc_nxt_out(crc_nxt), .fcs_nxt, .full_nxt);
  wmfp_decode u_dec (.clk, .rst_n, .step, .data_byte(b_r), .last_byte(l_r), .rel_ok,
                     .rel_byte, .crc_nxt, .fcs_nxt, .full_nxt, .rec_valid(rv), .rec);

  // record register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (!ov_r || out_tready) ov_r <= step && rv;
    if ((!ov_r || out_tready) && step && rv) o_r <= rec;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {o_r.idx, o_r.value};
  assign out_tuser  = {o_r.status, o_r.done, o_r.frag, o_r.kind};

`ifndef SYNTH
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[9] == (out_tuser[4:0] == wmfp_pkg::KIND_END)))
    else $error("done flag mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("record lost under stall");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[9] |-> out_tuser[12:10] == wmfp_pkg::ST_OK)
    else $error("status on non-end record");
`endif
endmodule
`default_nettype wire

// ===== src/wmfp_trail.sv =====
// Four-byte delay line with the CRC-32 over bytes leaving it.
`default_nettype none
module wmfp_trail (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic        clear,
  input  wire logic [7:0]  data_byte,
  output logic             rel_ok,
  output logic [7:0]       rel_byte,
  output logic [31:0]      crc_nxt_out,
  output logic [31:0]      fcs_nxt,
  output logic             full_nxt
);
  logic [7:0]  tb_r [4];
  logic [7:0]  tb_nxt [4];
  logic [2:0]  fill_r, fill_nxt;
  logic [31:0] crc_r, crc_nxt;

  // shift or fill
  always_comb begin
    tb_nxt   = tb_r;
    fill_nxt = fill_r;
    crc_nxt  = crc_r;
    rel_ok   = fill_r[2];
    rel_byte = tb_r[0];
    if (fill_r[2]) begin
      crc_nxt  = wmfp_pkg::crc_byte(crc_r, tb_r[0]);
      tb_nxt[0] = tb_r[1];
      tb_nxt[1] = tb_r[2];
      tb_nxt[2] = tb_r[3];
      tb_nxt[3] = data_byte;
    end else begin
      tb_nxt[fill_r[1:0]] = data_byte;
      fill_nxt = fill_r + 3'd1;
    end
    crc_nxt_out = crc_nxt;
    fcs_nxt     = {tb_nxt[0], tb_nxt[1], tb_nxt[2], tb_nxt[3]};
    full_nxt    = fill_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && clear)) begin
      fill_r <= 3'd0;
      crc_r  <= 32'hFFFFFFFF;
      for (int i = 0; i < 4; i++) tb_r[i] <= 8'd0;
    end else if (step) begin
      fill_r <= fill_nxt;
      crc_r  <= crc_nxt;
      tb_r   <= tb_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/wmfp_decode.sv =====
// Field-position state and per-byte record decode.
`default_nettype none
module wmfp_decode (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic        rel_ok,
  input  wire logic [7:0]  rel_byte,
  input  wire logic [31:0] crc_nxt,
  input  wire logic [31:0] fcs_nxt,
  input  wire logic        full_nxt,
  output logic             rec_valid,
  output wmfp_pkg::rec_t   rec
);
  wmfp_pkg::phase_t ph_r, ph_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [3:0]  dir_r, dir_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [15:0] ec_r, ec_nxt;
  logic [2:0]  pend_r, pend_nxt;

  always_comb begin
    logic [15:0] bump;
    logic        rel, r, chk;
    logic [7:0]  ridx;
    logic [4:0]  k;
    logic [2:0]  st;
    bump = (ec_r == 16'hFFFF) ? ec_r : ec_r + 16'd1;
    ph_nxt = ph_r; cnt_nxt = cnt_r; acc_nxt = acc_r; type_nxt = type_r;
    dir_nxt = dir_r; rem_nxt = rem_r; ec_nxt = ec_r; pend_nxt = pend_r;
    r = 1'b0; k = 5'd0; chk = 1'b0; st = wmfp_pkg::ST_OK;
    rec = '0;
    rel  = rel_ok && ph_r == wmfp_pkg::PH_PAYLOAD && ec_r >= 16'd4;
    ridx = 8'(ec_r - 16'd4);
    case (ph_r)
      wmfp_pkg::PH_TYPE: begin
        type_nxt = data_byte; r = 1'b1; k = 5'd0; rec.value = {56'd0, data_byte};
        cnt_nxt = '0; acc_nxt = '0; ec_nxt = '0;
        if (wmfp_pkg::is_known(data_byte)) ph_nxt = wmfp_pkg::PH_FLAGS;
        else begin
          pend_nxt = (data_byte == wmfp_pkg::T_ACTION) ? wmfp_pkg::ST_ACT_IGN
                                                       : wmfp_pkg::ST_UNSUP;
          ph_nxt = wmfp_pkg::PH_SKIP;
        end
      end
      wmfp_pkg::PH_FLAGS: begin
        dir_nxt = (type_r == wmfp_pkg::T_ACK || type_r == wmfp_pkg::T_RTS ||
                   type_r == wmfp_pkg::T_CTS) ? 4'd0 : data_byte[3:0];
        r = 1'b1; k = 5'd1; rec.value = {60'd0, dir_nxt};
        ph_nxt = wmfp_pkg::PH_DUR; cnt_nxt = '0; acc_nxt = '0; ec_nxt = '0;
      end
      wmfp_pkg::PH_PAYLOAD, wmfp_pkg::PH_TAIL: ec_nxt = bump;
      wmfp_pkg::PH_SSID_ID, wmfp_pkg::PH_RATE_ID: begin
        ph_nxt = (ph_r == wmfp_pkg::PH_SSID_ID) ? wmfp_pkg::PH_SSID_LEN
                                                : wmfp_pkg::PH_RATE_LEN;
        cnt_nxt = '0; acc_nxt = '0; ec_nxt = '0;
      end
      wmfp_pkg::PH_SSID_LEN, wmfp_pkg::PH_RATE_LEN: begin
        cnt_nxt = '0; acc_nxt = '0; ec_nxt = '0;
        if (data_byte == 8'd0)
          ph_nxt = (ph_r == wmfp_pkg::PH_SSID_LEN) ? wmfp_pkg::PH_RATE_ID
                                                   : wmfp_pkg::PH_TAIL;
        else begin
          ph_nxt = (ph_r == wmfp_pkg::PH_SSID_LEN) ? wmfp_pkg::PH_SSID_BYTES
                                                   : wmfp_pkg::PH_RATE_BYTES;
          rem_nxt = data_byte;
        end
      end
      wmfp_pkg::PH_SSID_BYTES, wmfp_pkg::PH_RATE_BYTES: begin
        r = 1'b1;
        k = (ph_r == wmfp_pkg::PH_RATE_BYTES) ? wmfp_pkg::KIND_RATE : wmfp_pkg::KIND_SSID;
        rec.value = {56'd0, (ph_r == wmfp_pkg::PH_RATE_BYTES) ?
                     (data_byte & wmfp_pkg::RATE_MASK) : data_byte};
        rec.idx = ec_r[7:0];
        ec_nxt = bump;
        rem_nxt = rem_r - 8'd1;
        if (rem_nxt == 8'd0) begin
          ph_nxt = (ph_r == wmfp_pkg::PH_SSID_BYTES) ? wmfp_pkg::PH_RATE_ID
                                                     : wmfp_pkg::PH_TAIL;
          cnt_nxt = '0; acc_nxt = '0; ec_nxt = '0;
        end
      end
      wmfp_pkg::PH_SKIP: ;
      default: begin
        // multi-byte fixed field
        acc_nxt = {acc_r[55:0], data_byte};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_nxt >= wmfp_pkg::phase_len(ph_r)) begin
          k = wmfp_pkg::phase_kind(ph_r);
          if (k != wmfp_pkg::NO_REC) begin
            r = 1'b1;
            rec.value = acc_nxt;
            if (ph_r == wmfp_pkg::PH_SEQ) begin
              rec.frag  = acc_nxt[3:0];
              rec.value = {52'd0, acc_nxt[15:4]};
            end
          end
          ph_nxt = wmfp_pkg::next_phase(ph_r, type_r, dir_r[1:0]);
          cnt_nxt = '0; acc_nxt = '0; ec_nxt = '0;
        end
      end
    endcase
    rec.kind = k;
    // end-of-frame status
    if (pend_r != wmfp_pkg::ST_OK) st = pend_r;
    else if (pend_nxt != wmfp_pkg::ST_OK) st = pend_nxt;
    else if (ph_nxt == wmfp_pkg::PH_PAYLOAD) begin
      if (ec_nxt >= 16'd4) chk = 1'b1; else st = wmfp_pkg::ST_TRUNC;
    end else if (ph_nxt == wmfp_pkg::PH_TAIL) begin
      if (ec_nxt < 16'd4) st = wmfp_pkg::ST_TRUNC;
      else if (ec_nxt > 16'd4) st = wmfp_pkg::ST_EXTRA;
      else chk = 1'b1;
    end else st = wmfp_pkg::ST_TRUNC;
    if (chk && (!full_nxt || fcs_nxt != ~crc_nxt)) st = wmfp_pkg::ST_CRC;
    if (last_byte) begin
      rec = '0;
      rec.kind = wmfp_pkg::KIND_END; rec.done = 1'b1; rec.status = st;
      if (rel) begin
        rec.value = {55'd0, 1'b1, rel_byte}; rec.idx = ridx;
      end
      rec_valid = 1'b1;
    end else if (rel) begin
      rec = '0;
      rec.kind = wmfp_pkg::KIND_PAYLOAD; rec.value = {56'd0, rel_byte}; rec.idx = ridx;
      rec_valid = 1'b1;
    end else rec_valid = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      ph_r <= wmfp_pkg::PH_TYPE; cnt_r <= '0; acc_r <= '0; type_r <= '0;
      dir_r <= '0; rem_r <= '0; ec_r <= '0; pend_r <= '0;
    end else if (step) begin
      ph_r <= ph_nxt; cnt_r <= cnt_nxt; acc_r <= acc_nxt; type_r <= type_nxt;
      dir_r <= dir_nxt; rem_r <= rem_nxt; ec_r <= ec_nxt; pend_r <= pend_nxt;
    end
  end
endmodule
`default_nettype wire
